// File: rtl/decbc_pkg.sv
// Shared types, constants and codes for the double error correcting byte codec.
package decbc_pkg;

  // Code geometry: eight check rows over a sixteen column codeword.
  localparam int unsigned NROWS   = 8;
  localparam int unsigned NCOLS   = 16;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned CHECK_W = NROWS;
  localparam int unsigned CFG_IDX_W = 4;

  // One parity-check row; bit NCOLS-1 is codeword column 0.
  typedef logic [NCOLS-1:0] h_row_t;
  typedef h_row_t [NROWS-1:0] h_mat_t;

  // Power-on parity-check matrix, row 0 in the lowest slot.
  localparam h_mat_t H_RESET = {
    16'hE701, 16'h7B02, 16'h9504, 16'hE908,
    16'h5610, 16'hAA20, 16'hCC40, 16'hF080
  };

  // Operation codes.
  typedef enum logic {
    FUNC_ENCODE = 1'b0,
    FUNC_DECODE = 1'b1
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_CLEAN = 2'd0,
    ST_ONE   = 2'd1,
    ST_TWO   = 2'd2,
    ST_FAIL  = 2'd3
  } status_t;

  // One input request.
  typedef struct packed {
    func_t             func;
    logic [DATA_W-1:0] data_in;
    logic [CHECK_W-1:0] check_in;
  } req_t;

  // One result.
  typedef struct packed {
    logic [DATA_W-1:0]  data_out;
    logic [CHECK_W-1:0] parity_out;
    status_t            status;
  } rsp_t;

  // Register bank write request.
  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    h_row_t               data;
  } cfg_wr_t;

endpackage

// File: rtl/decbc_ifs.sv
// Channel interfaces for the codec: input requests, results and register writes.
interface decbc_in_if;
  import decbc_pkg::*;
  logic                valid;
  logic                ready;
  logic                func;
  logic [DATA_W-1:0]   data_in;
  logic [CHECK_W-1:0]  check_in;
  modport source (output valid, func, data_in, check_in, input ready);
  modport sink   (input valid, func, data_in, check_in, output ready);
endinterface

interface decbc_out_if;
  import decbc_pkg::*;
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   data_out;
  logic [CHECK_W-1:0]  parity_out;
  logic [1:0]          status;
  modport source (output valid, data_out, parity_out, status, input ready);
  modport sink   (input valid, data_out, parity_out, status, output ready);
endinterface

interface decbc_cfg_if;
  import decbc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [NCOLS-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/decbc_cfg_regs.sv
// Parity-check matrix register bank, written one row per request.
module decbc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  decbc_pkg::cfg_wr_t wr,
  output decbc_pkg::h_mat_t h_mat
);
  import decbc_pkg::*;

  h_mat_t h_mat_r;
  h_mat_t h_mat_nxt;

  // Rows beyond the matrix are ignored.
  always_comb begin
    h_mat_nxt = h_mat_r;
    if (wr.valid && (wr.index < CFG_IDX_W'(NROWS))) begin
      h_mat_nxt[wr.index[$clog2(NROWS)-1:0]] = wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_mat_r <= H_RESET;
    end else begin
      h_mat_r <= h_mat_nxt;
    end
  end

  assign h_mat = h_mat_r;

endmodule

// File: rtl/decbc_err_locate.sv
// Error locator: matches the syndrome against column pairs, then single columns.
module decbc_err_locate (
  input  decbc_pkg::h_mat_t        h_mat,
  input  logic [decbc_pkg::NROWS-1:0] syn,
  output logic [decbc_pkg::NCOLS-1:0] flip_mask,
  output decbc_pkg::status_t       status
);
  import decbc_pkg::*;

  logic [NROWS-1:0] col [NCOLS];
  logic             found2;
  logic             found1;
  logic [NCOLS-1:0] mask2;
  logic [NCOLS-1:0] mask1;

  // Column syndromes are a rewiring of the matrix rows.
  always_comb begin
    for (int i = 0; i < NCOLS; i++) begin
      for (int r = 0; r < NROWS; r++) begin
        col[i][NROWS-1-r] = h_mat[r][NCOLS-1-i];
      end
    end
  end

  // First matching pair in (i, j) order wins.
  always_comb begin
    found2 = 1'b0;
    mask2  = '0;
    for (int i = 0; i < NCOLS - 1; i++) begin
      for (int j = i + 1; j < NCOLS; j++) begin
        if (!found2 && ((col[i] ^ col[j]) == syn)) begin
          found2             = 1'b1;
          mask2[NCOLS-1-i]   = 1'b1;
          mask2[NCOLS-1-j]   = 1'b1;
        end
      end
    end
  end

  // Lowest matching single column.
  always_comb begin
    found1 = 1'b0;
    mask1  = '0;
    for (int i = 0; i < NCOLS; i++) begin
      if (!found1 && (col[i] == syn)) begin
        found1           = 1'b1;
        mask1[NCOLS-1-i] = 1'b1;
      end
    end
  end

  // A double correction takes precedence over a single one.
  always_comb begin
    priority if (syn == '0) begin
      flip_mask = '0;
      status    = ST_CLEAN;
    end else if (found2) begin
      flip_mask = mask2;
      status    = ST_TWO;
    end else if (found1) begin
      flip_mask = mask1;
      status    = ST_ONE;
    end else begin
      flip_mask = '0;
      status    = ST_FAIL;
    end
  end

endmodule

// File: rtl/decbc_codec_core.sv
// Codec datapath: syndrome over the word, then parity out or corrected word.
module decbc_codec_core (
  input  decbc_pkg::h_mat_t h_mat,
  input  decbc_pkg::req_t   req,
  output decbc_pkg::rsp_t   rsp
);
  import decbc_pkg::*;

  logic [NCOLS-1:0] word;
  logic [NROWS-1:0] syn;
  logic [NCOLS-1:0] flip_mask;
  logic [NCOLS-1:0] fixed;
  status_t          loc_status;

  // Encode uses the same syndrome with the parity byte forced to zero.
  always_comb begin
    word = {req.data_in, (req.func == FUNC_DECODE) ? req.check_in : CHECK_W'(0)};
    for (int r = 0; r < NROWS; r++) begin
      syn[NROWS-1-r] = ^(h_mat[r] & word);
    end
  end

  decbc_err_locate u_locate (
    .h_mat     (h_mat),
    .syn       (syn),
    .flip_mask (flip_mask),
    .status    (loc_status)
  );

  assign fixed = word ^ flip_mask;

  // Select the result for the requested operation.
  always_comb begin
    unique case (req.func)
      FUNC_ENCODE: begin
        rsp.data_out   = req.data_in;
        rsp.parity_out = syn;
        rsp.status     = ST_CLEAN;
      end
      FUNC_DECODE: begin
        rsp.data_out   = fixed[NCOLS-1 -: DATA_W];
        rsp.parity_out = fixed[CHECK_W-1:0];
        rsp.status     = loc_status;
      end
      default: begin
        rsp.data_out   = req.data_in;
        rsp.parity_out = syn;
        rsp.status     = ST_CLEAN;
      end
    endcase
  end

endmodule

// File: rtl/double_error_correcting_byte_codec.sv
// Top level of the configurable (16,8) byte codec with double error correction.
//
// Channels: in_if carries one request (func, data_in, check_in); func selects
// encode of the data byte or decode of data_in:check_in. out_if returns one
// result per request (data_out, parity_out, status) in request order. cfg_if
// writes one 16-bit parity-check row per request; index 0 to 7 selects the
// row and other indices are dropped. cfg_if is always ready.
// A request accepted on in_if is held in the input register, processed by
// combinational logic and shown on out_if from the result register.
// Throughput: one request per cycle unless out_if stalls; two pipeline registers
// are the only storage; syndrome and column-pair matching are combinational.
// Stall: while out_if holds a result that is not taken, the input register
// can still take one more request; after that in_if.ready drops until the
// receiver takes the result.
// Reset (rst_n low, synchronous): both pipeline stages empty and the matrix
// rows return to their power-on values. Rows should be written only while no
// request is in flight.
module double_error_correcting_byte_codec (
  input  logic       clk,
  input  logic       rst_n,
  decbc_in_if.sink   in_if,
  decbc_out_if.source out_if,
  decbc_cfg_if.sink  cfg_if
);
  import decbc_pkg::*;

  h_mat_t  h_mat;
  cfg_wr_t cfg_wr;
  logic    s1_valid_r;
  logic    s1_valid_nxt;
  req_t    s1_req_r;
  logic    out_valid_r;
  logic    out_valid_nxt;
  rsp_t    out_rsp_r;
  rsp_t    core_rsp;
  logic    advance;
  logic    in_ready;

  // Register bank.
  assign cfg_if.ready = 1'b1;
  assign cfg_wr = '{valid: cfg_if.valid, index: cfg_if.index, data: cfg_if.data};

  decbc_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (cfg_wr),
    .h_mat (h_mat)
  );

  // Pipeline control: the output stage moves when empty or taken.
  assign advance      = !out_valid_r || out_if.ready;
  assign in_ready     = advance || !s1_valid_r;
  assign in_if.ready  = in_ready;
  assign s1_valid_nxt = in_ready ? in_if.valid : s1_valid_r;
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_ready && in_if.valid) begin
      s1_req_r <= '{func: func_t'(in_if.func), data_in: in_if.data_in,
                    check_in: in_if.check_in};
    end
  end

  decbc_codec_core u_core (
    .h_mat (h_mat),
    .req   (s1_req_r),
    .rsp   (core_rsp)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_rsp_r <= core_rsp;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.data_out   = out_rsp_r.data_out;
  assign out_if.parity_out = out_rsp_r.parity_out;
  assign out_if.status     = out_rsp_r.status;

`ifndef ASSERT_OFF
  // A full, stalled pipeline must not take another request.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_if.ready) |-> !in_if.ready)
    else $error("request accepted into a full pipeline");

  // A pending request moves to the output when the result is taken.
  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_if.ready && s1_valid_r) |=> out_if.valid)
    else $error("pending request lost after result was taken");

  // Encode results always report a clean status.
  a_encode_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_valid_r && (s1_req_r.func == FUNC_ENCODE))
      |=> (out_if.status == ST_CLEAN))
    else $error("encode result carries a correction status");
`endif

endmodule

// File: test/decbc_result_check.sv
`timescale 1ns / 1ps
// Checker for the byte codec: tracks the matrix rows, predicts each result and compares.
module codec_result_check (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_func,
  input  logic [decbc_pkg::DATA_W-1:0]  in_data,
  input  logic [decbc_pkg::CHECK_W-1:0] in_check,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [decbc_pkg::DATA_W-1:0]  out_data,
  input  logic [decbc_pkg::CHECK_W-1:0] out_parity,
  input  logic [1:0]                   out_status,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [decbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [decbc_pkg::NCOLS-1:0]   cfg_data,
  output int                           pending,
  output int                           fail_count
);
  import decbc_pkg::*;

  // Our own copy of the parity-check rows and the results still owed by the block.
  h_row_t check_rows [NROWS];
  rsp_t   awaited_results [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Syndrome of a 16-bit pattern; row 0 lands in the top bit.
  function automatic logic [7:0] word_syndrome(input logic [NCOLS-1:0] word);
    logic [7:0] syn;
    for (int r = 0; r < NROWS; r++) begin
      syn[NROWS-1-r] = ^(check_rows[r] & word);
    end
    return syn;
  endfunction

  // Expected result of one request under the current rows.
  function automatic rsp_t codec_result(input func_t op, input logic [7:0] data,
                                        input logic [7:0] check);
    rsp_t             res;
    logic [NCOLS-1:0] word;
    logic [7:0]       syn;
    logic [7:0]       col_syn [NCOLS];
    logic             fixed;
    res.status = ST_CLEAN;
    fixed = 1'b0;
    if (op == FUNC_ENCODE) begin
      word = {data, word_syndrome({data, 8'h00})};
    end else begin
      word = {data, check};
      syn = word_syndrome(word);
      if (syn != 8'h00) begin
        for (int c = 0; c < NCOLS; c++) begin
          col_syn[c] = word_syndrome(16'h8000 >> c);
        end
        // Column pairs are tried first, lowest i then lowest j.
        for (int i = 0; i < NCOLS - 1; i++) begin
          for (int j = i + 1; j < NCOLS; j++) begin
            if (!fixed && (col_syn[i] ^ col_syn[j]) == syn) begin
              word = word ^ (16'h8000 >> i) ^ (16'h8000 >> j);
              res.status = ST_TWO;
              fixed = 1'b1;
            end
          end
        end
        // Then a single column, lowest first.
        for (int c = 0; c < NCOLS; c++) begin
          if (!fixed && col_syn[c] == syn) begin
            word = word ^ (16'h8000 >> c);
            res.status = ST_ONE;
            fixed = 1'b1;
          end
        end
        if (!fixed) begin
          res.status = ST_FAIL;
        end
      end
    end
    res.data_out = word[15:8];
    res.parity_out = word[7:0];
    return res;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want_v, got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %h, got %h", field, want_v, got_v);
      fail_count++;
    end
  endtask

  // Everything is sampled at the clock edge, before the edge's updates land.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      for (int r = 0; r < NROWS; r++) begin
        check_rows[r] = H_RESET[r];
      end
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < NROWS) begin
        check_rows[cfg_index[2:0]] = cfg_data;
      end
      // Retire a result before taking a new request, so nothing can match early.
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: data_out %h parity_out %h status %0d",
                 out_data, out_parity, out_status);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("data_out", want.data_out, out_data);
          check_field("parity_out", want.parity_out, out_parity);
          check_field("status", {6'd0, want.status}, {6'd0, out_status});
        end
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(codec_result(func_t'(in_func), in_data, in_check));
      end
    end
    pending = awaited_results.size();
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the byte codec: clock, reset, request stimulus and the verdict.
module tb_top;
  import decbc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] STRAY_ROW_INDEX = 4'hF;

  logic clk;
  logic rst_n;
  int   pending;
  int   fail_count;
  int   cycle_count;

  // Stimulus knobs, some of them read by the receiver process.
  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_cycles;
  h_mat_t stim_rows;

  decbc_in_if  in_ch ();
  decbc_out_if out_ch ();
  decbc_cfg_if cfg_ch ();

  double_error_correcting_byte_codec dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  codec_result_check result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_func    (in_ch.func),
    .in_data    (in_ch.data_in),
    .in_check   (in_ch.check_in),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_ch.data_out),
    .out_parity (out_ch.parity_out),
    .out_status (out_ch.status),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // Receiver: random backpressure, or a long hold-off when one is asked for.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Parity byte of a data byte under the rows last written.
  function automatic logic [7:0] parity_for(input logic [7:0] data);
    logic [7:0] par;
    for (int r = 0; r < NROWS; r++) begin
      par[NROWS-1-r] = ^(stim_rows[r][15:8] & data);
    end
    return par;
  endfunction

  // Two distinct error positions.
  function automatic logic [NCOLS-1:0] pair_mask();
    int i;
    int j;
    i = $urandom_range(NCOLS - 1);
    j = $urandom_range(NCOLS - 2);
    if (j >= i) begin
      j++;
    end
    return (16'h8000 >> i) | (16'h8000 >> j);
  endfunction

  // Random left half; the right half is the identity when the code is systematic.
  function automatic h_mat_t random_matrix(input bit systematic);
    h_mat_t m;
    for (int r = 0; r < NROWS; r++) begin
      m[r] = systematic ? {8'($urandom), 8'h80 >> r} : 16'($urandom);
    end
    return m;
  endfunction

  // Offer one request, idling first at random, and return once it is taken.
  task automatic send_request(input func_t op, input logic [7:0] data, input logic [7:0] check);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= op;
    in_ch.data_in <= data;
    in_ch.check_in <= check;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
  endtask

  // Decode request for an encoded byte with the given bits flipped.
  task automatic send_codeword(input logic [7:0] data, input logic [NCOLS-1:0] flips);
    logic [NCOLS-1:0] word;
    word = {data, parity_for(data)} ^ flips;
    send_request(FUNC_DECODE, word[15:8], word[7:0]);
  endtask

  // A mix of encode requests, well-formed codewords with zero, one or two errors, and noise.
  task automatic run_random(input int count);
    int         pick;
    logic [7:0] data;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      data = 8'($urandom);
      if (pick < 20) begin
        send_request(FUNC_ENCODE, data, 8'($urandom));
      end else if (pick < 35) begin
        send_codeword(data, 16'h0000);
      end else if (pick < 60) begin
        send_codeword(data, 16'h8000 >> $urandom_range(NCOLS - 1));
      end else if (pick < 85) begin
        send_codeword(data, pair_mask());
      end else begin
        send_request(FUNC_DECODE, data, 8'($urandom));
      end
    end
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  // Write all eight rows while the block is idle, optionally with an out-of-range index.
  task automatic load_matrix(input h_mat_t m, input bit add_stray);
    drain_results();
    for (int r = 0; r < NROWS; r++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= CFG_IDX_W'(r);
      cfg_ch.data <= m[r];
      @(posedge clk);
      while (!cfg_ch.ready) begin
        @(posedge clk);
      end
    end
    if (add_stray) begin
      cfg_ch.index <= STRAY_ROW_INDEX;
      cfg_ch.data <= 16'($urandom);
      @(posedge clk);
      while (!cfg_ch.ready) begin
        @(posedge clk);
      end
    end
    cfg_ch.valid <= 1'b0;
    stim_rows = m;
  endtask

  // Main sequence.
  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_ENCODE;
    in_ch.data_in <= 8'h00;
    in_ch.check_in <= 8'h00;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    send_idle_pct = 12;
    recv_idle_pct = 83;
    hold_cycles = 0;
    stim_rows = H_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Power-on matrix: encode extremes, check byte ignored on encode.
    send_request(FUNC_ENCODE, 8'h00, 8'hFF);
    send_request(FUNC_ENCODE, 8'hFF, 8'h00);
    send_request(FUNC_ENCODE, 8'h80, 8'hA5);
    send_request(FUNC_ENCODE, 8'h01, 8'h5A);
    // Clean words, including the all-zero word.
    send_codeword(8'h00, 16'h0000);
    send_codeword(8'hFF, 16'h0000);
    send_codeword(8'hA5, 16'h0000);
    // Single errors at both ends and across the data/parity boundary.
    send_codeword(8'h5C, 16'h8000);
    send_codeword(8'h5C, 16'h0001);
    send_codeword(8'h5C, 16'h0100);
    send_codeword(8'h5C, 16'h0080);
    // Double errors, first and last pairs and boundary straddles.
    send_codeword(8'h3A, 16'hC000);
    send_codeword(8'h3A, 16'h0003);
    send_codeword(8'h3A, 16'h8001);
    send_codeword(8'h3A, 16'h0180);
    // Heavier damage, likely beyond repair.
    send_codeword(8'h3A, 16'h8421);
    send_codeword(8'h96, 16'hF000);
    send_request(FUNC_DECODE, 8'hFF, 8'hFF);
    send_request(FUNC_DECODE, 8'h00, 8'h01);
    run_random(300);

    load_matrix(random_matrix(1'b1), 1'b0);
    run_random(250);

    // Now the sender is the slow side.
    send_idle_pct = 83;
    recv_idle_pct = 12;

    // All-ones rows: every column looks alike, so only column 0 can be fixed.
    load_matrix('1, 1'b0);
    send_request(FUNC_DECODE, 8'hFF, 8'hFE);
    send_request(FUNC_DECODE, 8'h00, 8'h00);
    send_request(FUNC_ENCODE, 8'hFF, 8'h00);
    run_random(100);

    // All-zero rows: every syndrome is zero.
    load_matrix('0, 1'b0);
    run_random(100);

    load_matrix(random_matrix(1'b0), 1'b0);
    run_random(250);

    // No idling; back to the power-on rows plus a write that must be dropped.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_matrix(H_RESET, 1'b1);
    hold_cycles = 60;
    run_random(30);
    drain_results();
    run_random(350);

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
